// ----- rtl/core/shcd_pkg.sv -----
// Shared types, constants and helper functions for the settable hh:mm clock display.
// No dependencies; every other file of the block imports it.
`default_nettype none

package shcd_pkg;

  // Blink half period and the reciprocal used to take now_ms / BLINK_HALF_MS
  localparam int unsigned BLINK_HALF_MS = 300;
  localparam int unsigned DIGIT_COUNT   = 4;
  localparam int unsigned BLINK_SHIFT   = 32 + $clog2(BLINK_HALF_MS);
  localparam logic [63:0] BLINK_MAGIC64 =
    ((64'd1 << BLINK_SHIFT) + 64'(BLINK_HALF_MS) - 64'd1) / 64'(BLINK_HALF_MS);
  localparam logic [32:0] BLINK_MAGIC   = BLINK_MAGIC64[32:0];

  // Reset values
  localparam logic [9:0]  LOW_THR_RST    = 10'd300;
  localparam logic [9:0]  HIGH_THR_RST   = 10'd700;
  localparam logic [31:0] MIN_PERIOD_RST = 32'd60000;
  localparam logic [4:0]  HOUR_RST       = 5'd12;
  localparam logic [5:0]  MINUTE_RST     = 6'd0;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] REG_LOW_THR    = 2'd0;
  localparam logic [1:0] REG_HIGH_THR   = 2'd1;
  localparam logic [1:0] REG_MIN_PERIOD = 2'd2;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    DIG_HOUR_TENS = 2'd0,
    DIG_HOUR_ONES = 2'd1,
    DIG_MIN_TENS  = 2'd2,
    DIG_MIN_ONES  = 2'd3
  } shcd_digit_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_pressed;
    logic [9:0]  joy_x;
    logic [9:0]  joy_y;
  } shcd_item_t;

  typedef struct packed {
    logic [9:0]  low_threshold;
    logic [9:0]  high_threshold;
    logic [31:0] minute_period_ms;
  } shcd_cfg_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
  } shcd_time_t;

  typedef struct packed {
    shcd_time_t  tm;
    logic        set_mode;
    shcd_digit_e digit;
  } shcd_view_t;

  // Add or subtract 10 or 1 on the selected digit, wrap the touched unit to the far end
  function automatic shcd_time_t step_digit(shcd_time_t t, shcd_digit_e dig, logic up);
    logic signed [7:0] h;
    logic signed [7:0] m;
    logic signed [7:0] step;
    shcd_time_t r;
    h = signed'({3'b000, t.hours});
    m = signed'({2'b00, t.minutes});
    case (dig)
      DIG_HOUR_TENS, DIG_MIN_TENS: step = 8'sd10;
      default:                     step = 8'sd1;
    endcase
    if (!up) begin
      step = -step;
    end
    case (dig)
      DIG_HOUR_TENS, DIG_HOUR_ONES: h = h + step;
      DIG_MIN_TENS, DIG_MIN_ONES:   m = m + step;
      default:                      h = h;
    endcase
    if (h < 8'sd0) begin
      h = 8'sd23;
    end else if (h > 8'sd23) begin
      h = 8'sd0;
    end
    if (m < 8'sd0) begin
      m = 8'sd59;
    end else if (m > 8'sd59) begin
      m = 8'sd0;
    end
    r.hours   = h[4:0];
    r.minutes = m[5:0];
    return r;
  endfunction

  // Tens digit of a value below 64
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(logic [5:0] v);
    logic [6:0] tens10;
    logic [6:0] diff;
    tens10 = 7'(tens_of(v)) * 7'd10;
    diff   = {1'b0, v} - tens10;
    return diff[3:0];
  endfunction

  // Active-low segments a..g in bits 0..6; codes above nine go dark
  function automatic logic [6:0] seg_lut(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shcd_cfg_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on shcd_pkg for register indexes, reset values and the config struct.
`default_nettype none

module shcd_cfg_regs
  import shcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output shcd_cfg_t        cfg_o
);

  logic [9:0]  low_thr_q;
  logic [9:0]  high_thr_q;
  logic [31:0] min_period_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q    <= LOW_THR_RST;
      high_thr_q   <= HIGH_THR_RST;
      min_period_q <= MIN_PERIOD_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LOW_THR:    low_thr_q    <= pwdata[9:0];
        REG_HIGH_THR:   high_thr_q   <= pwdata[9:0];
        REG_MIN_PERIOD: min_period_q <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW_THR:    prdata = {22'd0, low_thr_q};
      REG_HIGH_THR:   prdata = {22'd0, high_thr_q};
      REG_MIN_PERIOD: prdata = min_period_q;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.low_threshold    = low_thr_q;
  assign cfg_o.high_threshold   = high_thr_q;
  assign cfg_o.minute_period_ms = min_period_q;

endmodule

`default_nettype wire

// ----- rtl/core/shcd_in_stage.sv -----
// Input register: captures one poll item and hands it on when the result side is free.
// Depends on shcd_pkg for the item struct and tdata width.
`default_nettype none

module shcd_in_stage
  import shcd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   out_free_i,
  output logic                        advance_o,
  output shcd_item_t                  item_o
);

  logic       valid_q;
  shcd_item_t item_q;
  shcd_item_t item_d;

  assign advance_o  = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | advance_o;

  always_comb begin
    item_d.now_ms         = in_data_i[31:0];
    item_d.button_pressed = in_data_i[32];
    item_d.joy_x          = in_data_i[42:33];
    item_d.joy_y          = in_data_i[52:43];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ----- rtl/core/shcd_time_core.sv -----
// Clock state: mode toggle, joystick editing and the minute timer, one poll per advance.
// Depends on shcd_pkg for the digit step helper and shared structs.
`default_nettype none

module shcd_time_core
  import shcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire shcd_item_t  item_i,
  input  wire shcd_cfg_t   cfg_i,
  output shcd_view_t       view_o
);

  shcd_time_t  time_q, time_d, time_up, time_dn;
  logic        mode_q, mode_d;
  shcd_digit_e digit_q, digit_d, digit_r;
  logic [31:0] last_q, last_d;
  logic [31:0] elapsed;
  logic        y_up, y_dn, x_right, x_left;

  assign y_up    = item_i.joy_y < cfg_i.low_threshold;
  assign y_dn    = item_i.joy_y > cfg_i.high_threshold;
  assign x_right = item_i.joy_x > cfg_i.high_threshold;
  assign x_left  = item_i.joy_x < cfg_i.low_threshold;

  always_comb begin
    mode_d  = mode_q ^ item_i.button_pressed;
    last_d  = (item_i.button_pressed && !mode_d) ? item_i.now_ms : last_q;
    time_d  = time_q;
    digit_d = digit_q;
    time_up = y_up ? step_digit(time_q, digit_q, 1'b1) : time_q;
    time_dn = y_dn ? step_digit(time_up, digit_q, 1'b0) : time_up;
    digit_r = x_right ? shcd_digit_e'(digit_q + 2'd1) : digit_q;
    elapsed = item_i.now_ms - last_d;
    if (mode_d) begin
      time_d  = time_dn;
      digit_d = x_left ? shcd_digit_e'(digit_r - 2'd1) : digit_r;
    end else if (elapsed >= cfg_i.minute_period_ms) begin
      last_d = item_i.now_ms;
      // advance one minute, carry into the hour, wrap at 23:59
      if (time_q.minutes >= MINUTE_MAX) begin
        time_d.minutes = 6'd0;
        time_d.hours   = (time_q.hours >= HOUR_MAX) ? 5'd0 : time_q.hours + 5'd1;
      end else begin
        time_d.minutes = time_q.minutes + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.hours   <= HOUR_RST;
      time_q.minutes <= MINUTE_RST;
      mode_q         <= 1'b0;
      digit_q        <= DIG_HOUR_TENS;
      last_q         <= 32'd0;
    end else if (advance_i) begin
      time_q  <= time_d;
      mode_q  <= mode_d;
      digit_q <= digit_d;
      last_q  <= last_d;
    end
  end

  assign view_o.tm       = time_d;
  assign view_o.set_mode = mode_d;
  assign view_o.digit    = digit_d;

endmodule

`default_nettype wire

// ----- rtl/core/shcd_out_stage.sv -----
// Result register: segment decode, blink mask and packing of the result item.
// Depends on shcd_pkg for the digit split, segment table and blink reciprocal.
`default_nettype none

module shcd_out_stage
  import shcd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    advance_i,
  input  wire logic [31:0]             now_ms_i,
  input  wire shcd_view_t              view_i,
  output logic                         out_free_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [OUT_TDATA_W-1:0]       out_data_o
);

  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic [64:0]            blink_prod;
  logic                   blank;
  logic [3:0]             visible;
  logic [6:0]             seg_ht, seg_ho, seg_mt, seg_mo;

  // Parity of now_ms / BLINK_HALF_MS through the reciprocal
  assign blink_prod = 65'(now_ms_i) * 65'(BLINK_MAGIC);
  assign blank      = view_i.set_mode & ~blink_prod[BLINK_SHIFT];

  always_comb begin
    visible = '1;
    if (blank) begin
      visible[view_i.digit] = 1'b0;
    end
    seg_ht = seg_lut(tens_of({1'b0, view_i.tm.hours}));
    seg_ho = seg_lut(ones_of({1'b0, view_i.tm.hours}));
    seg_mt = seg_lut(tens_of(view_i.tm.minutes));
    seg_mo = seg_lut(ones_of(view_i.tm.minutes));
    data_d = {2'b00, visible, seg_mo, seg_mt, seg_ho, seg_ht,
              view_i.digit, view_i.set_mode, view_i.tm.minutes, view_i.tm.hours};
  end

  assign out_free_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= advance_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/settable_hhmm_clock_display_unit.sv -----
// Top level of the settable hh:mm clock display: input register, clock state, result register.
// Depends on shcd_pkg, shcd_cfg_regs, shcd_in_stage, shcd_time_core and shcd_out_stage.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      poll item, 53 bits in 56
//   m_axis    out        m_axis_tvalid/tready      result item, 46 bits in 48
//   apb       in         psel/penable, pready=1    3 registers at 0x0, 0x4, 0x8
//
// One item per cycle when unstalled; a poll passes the input, then the result register.
// The clock state updates as an item moves from the input register to the result register.
// Reset loads 12:00, run mode, hour-tens selected and a minute timer origin of zero.
// A stalled result holds in the result register while one more item waits in the input register.
`default_nettype none

module settable_hhmm_clock_display_unit
  import shcd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] now_ms, [32] button_pressed, [42:33] joy_x, [52:43] joy_y, [55:53] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [4:0] hours_out, [10:5] minutes_out, [11] set_mode_out, [13:12] selected_digit,
  // [20:14] seg_hour_tens, [27:21] seg_hour_ones, [34:28] seg_minute_tens,
  // [41:35] seg_minute_ones, [45:42] digit_visible, [47:46] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  shcd_cfg_t  cfg;
  shcd_item_t item;
  shcd_view_t view;
  logic       advance;
  logic       out_free;

  shcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  shcd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .out_free_i (out_free),
    .advance_o  (advance),
    .item_o     (item)
  );

  shcd_time_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg),
    .view_o    (view)
  );

  shcd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .now_ms_i    (item.now_ms),
    .view_i      (view),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/shcd_checker.sv -----
// Port-level checks on the result stream of the clock display, bound to the top level.
// Depends on shcd_pkg for the tdata width.
`default_nettype none

module shcd_checker
  import shcd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'd23) && (m_axis_tdata[10:5] <= 6'd59))
    else $error("time out of range");

  // All digits lit outside set mode
  a_run_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[11] |-> m_axis_tdata[45:42] == 4'hF)
    else $error("digit blanked in run mode");

  // At most the selected digit goes dark
  a_one_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |->
      (m_axis_tdata[45:42] == 4'hF) ||
      ($countones(m_axis_tdata[45:42]) == 3 &&
       !m_axis_tdata[42 + m_axis_tdata[13:12]]))
    else $error("wrong digit blanked");

endmodule

bind settable_hhmm_clock_display_unit shcd_checker u_shcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
